>>> sv/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");

// Clocked assertion that also holds across reset
`define ASSERT_CLK_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

>>> sv/gdip_pkg.sv
// Types, constants and microcode table of the gadget decomposition inner product
`default_nettype none

package gdip_pkg;

    localparam int WORD_W     = 32;
    localparam int BASE_W     = 17;
    localparam int CNT_W      = 3;
    localparam int KEY_FIELDS = 4;
    localparam int KEY_IDX_W  = $clog2(KEY_FIELDS);
    localparam int PROD_W     = WORD_W + BASE_W;
    localparam int DIVR_W     = WORD_W + 1;
    localparam int DSTEP_W    = $clog2(PROD_W + 1);
    localparam int PC_W       = 4;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_BASE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT = 2'd2;

    localparam logic [WORD_W-1:0] MODULUS_RST = 32'd16384;
    localparam logic [BASE_W-1:0] BASE_RST    = 17'd32;
    localparam logic [CNT_W-1:0]  COUNT_RST   = 3'd3;

    localparam logic [DSTEP_W-1:0] STEPS_WORD = DSTEP_W'(WORD_W);
    localparam logic [DSTEP_W-1:0] STEPS_PROD = DSTEP_W'(PROD_W);

    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t STEP_IDLE     = 4'd0;
    localparam pc_t STEP_DIV_SUM  = 4'd1;
    localparam pc_t STEP_LOAD_SUM = 4'd2;
    localparam pc_t STEP_TEST     = 4'd3;
    localparam pc_t STEP_DIV_DIG  = 4'd4;
    localparam pc_t STEP_TAKE_DIG = 4'd5;
    localparam pc_t STEP_MUL      = 4'd6;
    localparam pc_t STEP_DIV_PROD = 4'd7;
    localparam pc_t STEP_ADD_PROD = 4'd8;
    localparam pc_t STEP_FINISH   = 4'd9;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_DIV_SUM,
        OP_LOAD_SUM,
        OP_DIV_DIGIT,
        OP_TAKE_DIGIT,
        OP_MUL,
        OP_DIV_PROD,
        OP_ADD_PROD,
        OP_FINISH
    } op_t;

    typedef enum logic [1:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_DIGITS_DONE
    } cond_t;

    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_NO_INPUT,
        HOLD_DIV_BUSY,
        HOLD_OUT_FULL
    } hold_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        hold_t hold;
        pc_t   target;
    } ucode_t;

    typedef struct packed {
        logic in_valid;
        logic div_busy;
        logic digits_done;
        logic out_full;
    } status_t;

    typedef struct packed {
        op_t  op;
        logic fire;
        logic idle;
    } ctrl_t;

    function automatic ucode_t ucode_rom(input pc_t step);
        ucode_t w;
        unique case (step)
            STEP_IDLE:     w = '{OP_ACCEPT,     COND_NEXT,        HOLD_NO_INPUT, STEP_IDLE};
            STEP_DIV_SUM:  w = '{OP_DIV_SUM,    COND_NEXT,        HOLD_NONE,     STEP_IDLE};
            STEP_LOAD_SUM: w = '{OP_LOAD_SUM,   COND_NEXT,        HOLD_DIV_BUSY, STEP_IDLE};
            STEP_TEST:     w = '{OP_NOP,        COND_DIGITS_DONE, HOLD_NONE,     STEP_FINISH};
            STEP_DIV_DIG:  w = '{OP_DIV_DIGIT,  COND_NEXT,        HOLD_NONE,     STEP_IDLE};
            STEP_TAKE_DIG: w = '{OP_TAKE_DIGIT, COND_NEXT,        HOLD_DIV_BUSY, STEP_IDLE};
            STEP_MUL:      w = '{OP_MUL,        COND_NEXT,        HOLD_NONE,     STEP_IDLE};
            STEP_DIV_PROD: w = '{OP_DIV_PROD,   COND_NEXT,        HOLD_NONE,     STEP_IDLE};
            STEP_ADD_PROD: w = '{OP_ADD_PROD,   COND_ALWAYS,      HOLD_DIV_BUSY, STEP_TEST};
            STEP_FINISH:   w = '{OP_FINISH,     COND_ALWAYS,      HOLD_OUT_FULL, STEP_IDLE};
            default:       w = '{OP_NOP,        COND_ALWAYS,      HOLD_NONE,     STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> sv/gdip_div.sv
// Shared restoring divider: one quotient bit per cycle, quotient and remainder out
`default_nettype none

module gdip_div (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic [gdip_pkg::PROD_W-1:0]       dividend,
    input  wire logic [gdip_pkg::DIVR_W-1:0]       divisor,
    input  wire logic [gdip_pkg::DSTEP_W-1:0]      steps,
    output logic                                   busy,
    output logic [gdip_pkg::WORD_W-1:0]            quotient,
    output logic [gdip_pkg::DIVR_W-1:0]            remainder
);

    logic [gdip_pkg::DIVR_W-1:0]  rem_reg, rem_next;
    logic [gdip_pkg::PROD_W-1:0]  dvd_reg, dvd_next;
    logic [gdip_pkg::DIVR_W-1:0]  dvs_reg;
    logic [gdip_pkg::DSTEP_W-1:0] cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic [gdip_pkg::DIVR_W:0]    trial;
    logic [gdip_pkg::DIVR_W:0]    diff;
    logic                         fits;

    always_comb begin
        trial = {rem_reg, dvd_reg[gdip_pkg::PROD_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = trial >= {1'b0, dvs_reg};
    end

    always_comb begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            dvd_next  = dividend;
            cnt_next  = steps;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? diff[gdip_pkg::DIVR_W-1:0] : trial[gdip_pkg::DIVR_W-1:0];
            dvd_next  = {dvd_reg[gdip_pkg::PROD_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            busy_next = cnt_reg != 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign busy      = busy_reg;
    assign quotient  = dvd_reg[gdip_pkg::WORD_W-1:0];
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> sv/gdip_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps
`default_nettype none

module gdip_seq (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire gdip_pkg::status_t status,
    output gdip_pkg::ctrl_t        ctrl
);

    gdip_pkg::pc_t    pc_reg, pc_next;
    gdip_pkg::ucode_t word;
    logic             hold;
    logic             taken;

    always_comb begin
        word = gdip_pkg::ucode_rom(pc_reg);
        unique case (word.hold)
            gdip_pkg::HOLD_NONE:     hold = 1'b0;
            gdip_pkg::HOLD_NO_INPUT: hold = !status.in_valid;
            gdip_pkg::HOLD_DIV_BUSY: hold = status.div_busy;
            gdip_pkg::HOLD_OUT_FULL: hold = status.out_full;
            default:                 hold = 1'b0;
        endcase
        unique case (word.cond)
            gdip_pkg::COND_NEXT:        taken = 1'b0;
            gdip_pkg::COND_ALWAYS:      taken = 1'b1;
            gdip_pkg::COND_DIGITS_DONE: taken = status.digits_done;
            default:                    taken = 1'b0;
        endcase
        priority if (hold) begin
            pc_next = pc_reg;
        end else if (taken) begin
            pc_next = word.target;
        end else begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= gdip_pkg::STEP_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl.op   = word.op;
    assign ctrl.fire = !hold;
    assign ctrl.idle = pc_reg == gdip_pkg::STEP_IDLE;

endmodule

`default_nettype wire

>>> sv/gadget_decompose_inner_product.sv
// Top level: gadget decomposition inner product with microcoded control
// Per word the shared bit-serial divider first reduces the running sum, then per digit
//   splits off the digit and reduces the product. One word in flight; next word taken
//   on return to idle.
// Reset (aresetn low, synchronous): registers back to defaults, running sum cleared,
//   output empty, sequencer at idle.
`default_nettype none

module gadget_decompose_inner_product #(
    parameter int MAX_DIGITS = 4
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // coefficient, key_word_zero, key_word_one, key_word_two, key_word_three
    input  wire logic [5*gdip_pkg::WORD_W-1:0]    s_tdata,
    input  wire logic                             s_tlast,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // sum_value
    output logic [gdip_pkg::WORD_W-1:0]           m_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic                             cfg_wr_en,
    input  wire logic [gdip_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [gdip_pkg::WORD_W-1:0]      cfg_wdata
);

    localparam int DIG_LIMIT = (MAX_DIGITS < gdip_pkg::KEY_FIELDS) ? MAX_DIGITS
                                                                   : gdip_pkg::KEY_FIELDS;

    logic [gdip_pkg::WORD_W-1:0]  modulus_reg;
    logic [gdip_pkg::BASE_W-1:0]  base_reg;
    logic [gdip_pkg::CNT_W-1:0]   count_reg;

    logic [gdip_pkg::WORD_W-1:0]  running_sum_reg;
    logic [gdip_pkg::WORD_W-1:0]  sum_reg;
    logic [gdip_pkg::WORD_W-1:0]  rest_reg;
    logic [gdip_pkg::WORD_W-1:0]  key_reg [gdip_pkg::KEY_FIELDS];
    logic                         last_reg;
    logic [gdip_pkg::CNT_W-1:0]   digit_idx_reg;
    logic [gdip_pkg::BASE_W-1:0]  digit_reg;
    logic [gdip_pkg::PROD_W-1:0]  prod_reg;
    logic [gdip_pkg::WORD_W-1:0]  out_data_reg;
    logic                         out_valid_reg;

    logic [gdip_pkg::DIVR_W-1:0]  m_eff;
    logic [gdip_pkg::CNT_W-1:0]   d_eff;
    logic                         base_small;
    logic [gdip_pkg::DIVR_W:0]    add_sum;
    logic [gdip_pkg::DIVR_W:0]    add_red;
    logic [gdip_pkg::WORD_W-1:0]  sum_new;

    gdip_pkg::status_t            status;
    gdip_pkg::ctrl_t              ctrl;

    logic                         div_start;
    logic [gdip_pkg::PROD_W-1:0]  div_dividend;
    logic [gdip_pkg::DIVR_W-1:0]  div_divisor;
    logic [gdip_pkg::DSTEP_W-1:0] div_steps;
    logic                         div_busy;
    logic [gdip_pkg::WORD_W-1:0]  div_quot;
    logic [gdip_pkg::DIVR_W-1:0]  div_rem;

    logic                         exec;

    always_comb begin
        m_eff = (modulus_reg == '0) ? {1'b1, {gdip_pkg::WORD_W{1'b0}}}
                                    : {1'b0, modulus_reg};
        d_eff = (count_reg > gdip_pkg::CNT_W'(DIG_LIMIT)) ? gdip_pkg::CNT_W'(DIG_LIMIT)
                                                           : count_reg;
        base_small = base_reg < gdip_pkg::BASE_W'(2);
        add_sum = {2'b0, sum_reg} + {1'b0, div_rem};
        add_red = add_sum - {1'b0, m_eff};
        sum_new = (add_sum >= {1'b0, m_eff}) ? add_red[gdip_pkg::WORD_W-1:0]
                                              : add_sum[gdip_pkg::WORD_W-1:0];
    end

    assign status.in_valid    = s_tvalid;
    assign status.div_busy    = div_busy;
    assign status.digits_done = digit_idx_reg == d_eff;
    assign status.out_full    = last_reg && out_valid_reg;

    gdip_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    assign exec = ctrl.fire;

    always_comb begin
        div_start    = 1'b0;
        div_dividend = {prod_reg};
        div_divisor  = m_eff;
        div_steps    = gdip_pkg::STEPS_PROD;
        unique case (ctrl.op)
            gdip_pkg::OP_DIV_SUM: begin
                div_start    = exec;
                div_dividend = {running_sum_reg, {gdip_pkg::BASE_W{1'b0}}};
                div_steps    = gdip_pkg::STEPS_WORD;
            end
            gdip_pkg::OP_DIV_DIGIT: begin
                div_start    = exec;
                div_dividend = {rest_reg, {gdip_pkg::BASE_W{1'b0}}};
                div_divisor  = {{(gdip_pkg::DIVR_W - gdip_pkg::BASE_W){1'b0}}, base_reg};
                div_steps    = gdip_pkg::STEPS_WORD;
            end
            gdip_pkg::OP_DIV_PROD: begin
                div_start    = exec;
            end
            default: begin
                div_start    = 1'b0;
            end
        endcase
    end

    gdip_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .steps     (div_steps),
        .busy      (div_busy),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= gdip_pkg::MODULUS_RST;
            base_reg    <= gdip_pkg::BASE_RST;
            count_reg   <= gdip_pkg::COUNT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                gdip_pkg::CFG_MODULUS:     modulus_reg <= cfg_wdata;
                gdip_pkg::CFG_DIGIT_BASE:  base_reg    <= cfg_wdata[gdip_pkg::BASE_W-1:0];
                gdip_pkg::CFG_DIGIT_COUNT: count_reg   <= cfg_wdata[gdip_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_sum_reg <= '0;
            out_valid_reg   <= 1'b0;
            last_reg        <= 1'b0;
            digit_idx_reg   <= '0;
        end else begin
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (exec) begin
                unique case (ctrl.op)
                    gdip_pkg::OP_ACCEPT: begin
                        rest_reg      <= s_tdata[gdip_pkg::WORD_W-1:0];
                        last_reg      <= s_tlast;
                        digit_idx_reg <= '0;
                        for (int k = 0; k < gdip_pkg::KEY_FIELDS; k++) begin
                            key_reg[k] <= s_tdata[(k+1)*gdip_pkg::WORD_W +: gdip_pkg::WORD_W];
                        end
                    end
                    gdip_pkg::OP_LOAD_SUM: begin
                        sum_reg <= div_rem[gdip_pkg::WORD_W-1:0];
                    end
                    gdip_pkg::OP_TAKE_DIGIT: begin
                        digit_reg <= base_small ? '0 : div_rem[gdip_pkg::BASE_W-1:0];
                        rest_reg  <= base_small ? rest_reg : div_quot;
                    end
                    gdip_pkg::OP_MUL: begin
                        prod_reg <= gdip_pkg::PROD_W'(digit_reg)
                                  * gdip_pkg::PROD_W'(key_reg[digit_idx_reg[gdip_pkg::KEY_IDX_W-1:0]]);
                    end
                    gdip_pkg::OP_ADD_PROD: begin
                        sum_reg       <= sum_new;
                        digit_idx_reg <= digit_idx_reg + 1'b1;
                    end
                    gdip_pkg::OP_FINISH: begin
                        if (last_reg) begin
                            out_data_reg    <= sum_reg;
                            out_valid_reg   <= 1'b1;
                            running_sum_reg <= '0;
                        end else begin
                            running_sum_reg <= sum_reg;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign s_tready = ctrl.idle;
    assign m_tdata  = out_data_reg;
    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

>>> sv/gdip_checker.sv
// Port-level checker for the inner product block, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module gdip_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic [5*gdip_pkg::WORD_W-1:0]    s_tdata,
    input wire logic                             s_tlast,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic [gdip_pkg::WORD_W-1:0]      m_tdata,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic                             cfg_wr_en,
    input wire logic [gdip_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input wire logic [gdip_pkg::WORD_W-1:0]      cfg_wdata
);

    logic unused_ok;
    assign unused_ok = ^{s_tdata, s_tlast, cfg_wr_en, cfg_addr, cfg_wdata};

    `ASSERT_CLK(out_held, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid)
    `ASSERT_CLK(out_stable, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata))
    `ASSERT_CLK(one_word_in_flight, aclk, aresetn, s_tvalid && s_tready |=> !s_tready)
    `ASSERT_CLK_ALWAYS(reset_empties_out, aclk, !aresetn |=> !m_tvalid && s_tready)

endmodule

bind gadget_decompose_inner_product gdip_checker u_gdip_checker (.*);

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench: gadget decomposition inner product, checked against a predictor
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT       = 4_000_000;
    localparam int SETTLE      = 37 + 87 * gdip_pkg::KEY_FIELDS + 40;
    localparam int PHASES      = 12;
    localparam int PHASE_WORDS = 158;
    localparam int HOLD_AT     = 40;
    localparam int HOLD_LEN    = 2500;

    typedef struct packed {
        logic                             last;
        logic [3:0][gdip_pkg::WORD_W-1:0] key;
        logic [gdip_pkg::WORD_W-1:0]      coef;
    } coef_word_t;

    typedef struct {
        bit                          cfg;
        logic [gdip_pkg::WORD_W-1:0] modv;
        logic [gdip_pkg::BASE_W-1:0] base;
        logic [gdip_pkg::CNT_W-1:0]  cnt;
        logic [gdip_pkg::WORD_W-1:0] coef;
        logic [gdip_pkg::WORD_W-1:0] key0;
        logic [gdip_pkg::WORD_W-1:0] key_rest;
        bit                          last;
        bit                          typed;
        logic [gdip_pkg::WORD_W-1:0] want;
    } plan_row_t;

    logic                               aclk = 1'b0;
    logic                               aresetn;
    logic [5*gdip_pkg::WORD_W-1:0]      s_tdata;
    logic                               s_tlast;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [gdip_pkg::WORD_W-1:0]        m_tdata;
    logic                               m_tvalid;
    logic                               m_tready;
    logic                               cfg_wr_en;
    logic [gdip_pkg::CFG_IDX_W-1:0]     cfg_addr;
    logic [gdip_pkg::WORD_W-1:0]        cfg_wdata;

    logic [gdip_pkg::WORD_W-1:0]        mod_reg;
    logic [gdip_pkg::BASE_W-1:0]        base_reg;
    logic [gdip_pkg::CNT_W-1:0]         count_reg;
    logic [gdip_pkg::WORD_W-1:0]        acc_sum;
    logic [gdip_pkg::WORD_W-1:0]        sum_queue [$];
    int                                 fail_count = 0;
    longint unsigned                    cycle_count = 0;
    bit                                 steady = 1'b0;

    //  cfg modulus      base     cnt coefficient  key 0        keys 1-3   last typed want
    plan_row_t plan [18] = '{
        '{0, 0,           0,       0, 0,           'hFFFF_FFFF, 'hFFFF_FFFF, 1, 1, 0},
        '{0, 0,           0,       0, 1,           5,           0,           1, 1, 5},
        '{0, 0,           0,       0, 'hFFFF_FFFF, 1,           1,           1, 1, 93},
        '{0, 0,           0,       0, 'hFFFF_FFFF, 'hFFFF_FFFF, 'hFFFF_FFFF, 0, 0, 0},
        '{0, 0,           0,       0, 'h1234_5678, 'h9E37_79B9, 'h7F4A_7C15, 1, 0, 0},
        '{1, 1,           32,      3, 'hFFFF_FFFF, 'hFFFF_FFFF, 'hFFFF_FFFF, 1, 1, 0},
        '{1, 0,           'h10000, 2, 'hFFFF_FFFF, 'hFFFF_FFFF, 'hFFFF_FFFF, 1, 0, 0},
        '{1, 'hFFFF_FFFF, 2,       4, 'hFFFF_FFFF, 'hFFFF_FFFF, 'hFFFF_FFFF, 1, 1, 0},
        '{0, 0,           0,       0, 'hF,         1,           1,           1, 1, 4},
        '{1, 16384,       0,       4, 'hFFFF_FFFF, 1,           1,           1, 1, 0},
        '{1, 16384,       1,       4, 'hFFFF_FFFF, 1,           1,           1, 1, 0},
        '{1, 0,           'h1FFFF, 2, 'hFFFF_FFFF, 1,           1,           1, 0, 0},
        '{1, 16384,       32,      0, 'hFFFF_FFFF, 1,           1,           0, 0, 0},
        '{0, 0,           0,       0, 'hFFFF_FFFF, 1,           1,           1, 1, 0},
        '{1, 16384,       32,      7, 'hFFFF_FFFF, 1,           1,           1, 1, 124},
        '{1, 16384,       32,      5, 'hFFFF_FFFF, 1,           1,           1, 1, 124},
        '{1, 0,           32,      1, 'hFFFF_FFFF, 'hFFFF_FFFF, 0,           0, 0, 0},
        '{1, 7,           32,      0, 0,           0,           0,           1, 0, 0}
    };

    gadget_decompose_inner_product dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // Folds one word into the running sum; returns 1 with the finished sum on a last word
    function automatic bit fold_word(input coef_word_t w,
                                     output logic [gdip_pkg::WORD_W-1:0] done_sum);
        longint unsigned m;
        longint unsigned rest;
        longint unsigned total;
        longint unsigned digit;
        longint unsigned key;
        int n;
        m = (mod_reg == '0) ? 64'h1_0000_0000 : 64'(mod_reg);
        rest = 64'(w.coef);
        total = 64'(acc_sum) % m;
        n = (count_reg > gdip_pkg::KEY_FIELDS) ? gdip_pkg::KEY_FIELDS : int'(count_reg);
        for (int j = 0; j < n; j++) begin
            if (base_reg < 2) begin
                digit = 0;
            end else begin
                digit = rest % base_reg;
                rest = rest / base_reg;
            end
            key = 64'(w.key[j]) % m;
            total = (total + digit * key % m) % m;
        end
        done_sum = total[gdip_pkg::WORD_W-1:0];
        acc_sum = w.last ? '0 : total[gdip_pkg::WORD_W-1:0];
        return w.last;
    endfunction

    function automatic coef_word_t random_word();
        coef_word_t w;
        case ($urandom_range(0, 3))
            0: w.coef = $urandom_range(0, 1023);
            1: w.coef = '1 - $urandom_range(0, 255);
            default: w.coef = $urandom();
        endcase
        for (int j = 0; j < gdip_pkg::KEY_FIELDS; j++) begin
            case ($urandom_range(0, 5))
                0: w.key[j] = '0;
                1: w.key[j] = '1;
                2: w.key[j] = (mod_reg == '0) ? $urandom() : $urandom() % mod_reg;
                default: w.key[j] = $urandom();
            endcase
        end
        w.last = ($urandom_range(0, 3) == 0);
        return w;
    endfunction

    task automatic send_word(input coef_word_t w, input bit typed,
                             input logic [gdip_pkg::WORD_W-1:0] want);
        int gap;
        logic [gdip_pkg::WORD_W-1:0] sum_val;
        gap = steady ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {w.key, w.coef};
        s_tlast  <= w.last;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (fold_word(w, sum_val))
            sum_queue = {sum_queue, (typed ? want : sum_val)};
    endtask

    // Registers change only once the block has drained
    task automatic write_settings(input logic [gdip_pkg::WORD_W-1:0] m,
                                  input logic [gdip_pkg::BASE_W-1:0] b,
                                  input logic [gdip_pkg::CNT_W-1:0] c);
        s_tvalid <= 1'b0;
        while (sum_queue.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= gdip_pkg::CFG_MODULUS;
        cfg_wdata <= m;
        @(posedge aclk);
        cfg_addr  <= gdip_pkg::CFG_DIGIT_BASE;
        cfg_wdata <= gdip_pkg::WORD_W'(b);
        @(posedge aclk);
        cfg_addr  <= gdip_pkg::CFG_DIGIT_COUNT;
        cfg_wdata <= gdip_pkg::WORD_W'(c);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        mod_reg   = m;
        base_reg  = b;
        count_reg = c;
    endtask

    always @(posedge aclk) begin : check_sums
        logic [gdip_pkg::WORD_W-1:0] want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (sum_queue.size() == 0) begin
                $error("sum_value: expected none, actual %h", m_tdata);
                fail_count++;
            end else begin
                want = sum_queue.pop_front();
                if (m_tdata !== want) begin
                    $error("sum_value: expected %h, actual %h", want, m_tdata);
                    fail_count++;
                end
            end
        end
    end

    // Result side; one long hold-off lets the block back up into its input
    initial begin : sum_sink
        int gap;
        int taken;
        taken = 0;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            gap = (taken == HOLD_AT) ? HOLD_LEN : (steady ? 0 : $urandom_range(0, 18));
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            taken++;
        end
    end

    initial begin : stimulus
        coef_word_t w;
        logic [gdip_pkg::WORD_W-1:0] m;
        logic [gdip_pkg::BASE_W-1:0] b;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= gdip_pkg::CFG_MODULUS;
        cfg_wdata <= '0;
        mod_reg   = gdip_pkg::MODULUS_RST;
        base_reg  = gdip_pkg::BASE_RST;
        count_reg = gdip_pkg::COUNT_RST;
        acc_sum   = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].cfg)
                write_settings(plan[i].modv, plan[i].base, plan[i].cnt);
            w.coef = plan[i].coef;
            w.key  = {plan[i].key_rest, plan[i].key_rest, plan[i].key_rest, plan[i].key0};
            w.last = plan[i].last;
            send_word(w, plan[i].typed, plan[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: write_settings(32'hFFFF_FFFF, 17'd2, 3'd4);
                1: write_settings(32'h0, 17'd65536, 3'd2);
                2: write_settings(32'd2, 17'h1FFFF, 3'd7);
                3: write_settings(32'd1, 17'd3, 3'd3);
                default: begin
                    case ($urandom_range(0, 3))
                        0: m = $urandom_range(2, 65536);
                        1: m = 32'h8000_0000 | $urandom();
                        default: m = $urandom();
                    endcase
                    case ($urandom_range(0, 2))
                        0: b = gdip_pkg::BASE_W'($urandom_range(2, 16));
                        1: b = gdip_pkg::BASE_W'($urandom_range(2, 65536));
                        default: b = gdip_pkg::BASE_W'($urandom_range(0, 131071));
                    endcase
                    write_settings(m, b, gdip_pkg::CNT_W'($urandom_range(0, 7)));
                end
            endcase
            steady = ($urandom_range(0, 3) == 0);
            repeat (PHASE_WORDS) send_word(random_word(), 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        while (sum_queue.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
+incdir+sv
sv/gdip_pkg.sv
sv/gdip_div.sv
sv/gdip_seq.sv
sv/gadget_decompose_inner_product.sv
sv/gdip_checker.sv
tb/sv/testbench.sv
